// File: design/iee_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator.
// ---------------------------------------------------------------------------
package iee_pkg;

  localparam int LitW = 31;
  localparam logic [LitW-1:0] LitMax = {LitW{1'b1}};

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SYNTAX   = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_LIT_OVF  = 3'd4;

  typedef enum logic [2:0] {
    PH_OPERAND = 3'd0,
    PH_LIT     = 3'd1,
    PH_OP      = 3'd2,
    PH_TRAIL   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ADD,
    S_DIV_INIT,
    S_DIV_ITER,
    S_DIV_DONE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic to_end;
    logic fold_zero;
    logic mul_lo;
    logic mul_hi;
    logic mul_add;
    logic div_init;
    logic div_iter;
    logic div_done;
    logic finish;
  } iee_cmd_t;

  typedef struct packed {
    logic need_fold;
    logic fold_mul;
    logic fold_zero;
    logic div_last;
    logic last;
    logic at_end;
  } iee_status_t;

endpackage
`default_nettype wire

// File: design/iee_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iee_ctrl
// Sequencer: takes items, runs the multiply and divide steps of a fold,
// and hands finished results to the output register.
// ---------------------------------------------------------------------------
module iee_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  wire                  result_stall,
  input  iee_pkg::iee_status_t st,
  output iee_pkg::iee_cmd_t    cmd
);
  import iee_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (st.need_fold) begin
          if (st.fold_mul)       state_next = S_MUL_LO;
          else if (st.fold_zero) state_next = S_EVAL;
          else                   state_next = S_DIV_INIT;
        end else if (st.last && !st.at_end) begin
          state_next = S_EVAL;
        end else if (st.last) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_MUL_ADD;
      S_MUL_ADD:  state_next = S_EVAL;
      S_DIV_INIT: state_next = S_DIV_ITER;
      S_DIV_ITER: begin
        if (st.div_last) state_next = S_DIV_DONE;
      end
      S_DIV_DONE: state_next = S_EVAL;
      S_FINISH: begin
        if (!result_valid || !result_stall) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE:     cmd.load = item_valid;
      S_EVAL: begin
        if (st.need_fold) begin
          cmd.fold_zero = !st.fold_mul && st.fold_zero;
        end else begin
          cmd.step   = 1'b1;
          cmd.to_end = st.last && !st.at_end;
        end
      end
      S_MUL_LO:   cmd.mul_lo = 1'b1;
      S_MUL_HI:   cmd.mul_hi = 1'b1;
      S_MUL_ADD:  cmd.mul_add = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV_ITER: cmd.div_iter = 1'b1;
      S_DIV_DONE: cmd.div_done = 1'b1;
      S_FINISH:   cmd.finish = !result_valid || !result_stall;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/iee_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iee_dp
// Datapath: parser state, running sum and product, shared 32x32 multiplier,
// radix-4 restoring divider and the result register.
// ---------------------------------------------------------------------------
module iee_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  iee_pkg::in_item_t    item,
  input  iee_pkg::iee_cmd_t    cmd,
  output iee_pkg::iee_status_t st,
  output iee_pkg::out_item_t   result
);
  import iee_pkg::*;

  // parser state
  phase_t          phase;
  logic [LitW-1:0] literal;
  logic [63:0]     running_sum;
  logic [63:0]     running_product;
  logic            pending_minus;
  logic            pending_divide;
  logic            divide_fault;
  logic [2:0]      error_code;

  // current character
  logic [7:0] cur_c;
  logic       cur_last;
  logic       at_end;

  // arithmetic units
  logic [63:0]     mreg;
  logic [63:0]     acc;
  logic [63:0]     dq;
  logic [LitW-1:0] rem;
  logic [4:0]      cnt;
  logic            neg;

  // step results
  phase_t          phase_next;
  logic [LitW-1:0] literal_next;
  logic [63:0]     running_sum_next;
  logic [63:0]     running_product_next;
  logic            pending_minus_next;
  logic            pending_divide_next;
  logic [2:0]      error_code_next;

  logic            is_digit;
  logic            is_space;
  logic            is_op;
  logic            active;
  logic [3:0]      digit;
  logic [LitW+3:0] lit_ext;
  logic [63:0]     fold_sum;
  logic [31:0]     mul_a;
  logic [63:0]     mul_res;
  logic [LitW:0]   t1;
  logic [LitW:0]   t2;
  logic            ge1;
  logic            ge2;
  logic [LitW-1:0] r1;
  logic [LitW-1:0] r2;

  assign is_digit = (cur_c >= CH_ZERO) && (cur_c <= CH_NINE);
  assign is_space = (cur_c == CH_SPACE) || ((cur_c >= CH_TAB) && (cur_c <= CH_CR));
  assign is_op    = (cur_c == CH_PLUS) || (cur_c == CH_MINUS) ||
                    (cur_c == CH_STAR) || (cur_c == CH_SLASH);
  assign active   = (error_code == ST_OK) && (phase < PH_DONE);
  assign digit    = cur_c[3:0];
  assign lit_ext  = {1'b0, literal, 3'b000} + {3'b000, literal, 1'b0} +
                    {{(LitW){1'b0}}, digit};
  assign fold_sum = pending_minus ? running_sum - running_product
                                  : running_sum + running_product;

  assign st.need_fold = active && (phase == PH_LIT) && !is_digit;
  assign st.fold_mul  = !pending_divide;
  assign st.fold_zero = pending_divide && (literal == '0);
  assign st.div_last  = (cnt == 5'd31);
  assign st.last      = cur_last;
  assign st.at_end    = at_end;

  // shared multiplier: low or high half of the product times the literal
  assign mul_a   = cmd.mul_hi ? running_product[63:32] : running_product[31:0];
  assign mul_res = mul_a * {{(32-LitW){1'b0}}, literal};

  // two quotient bits per cycle
  assign t1  = {rem, dq[63]};
  assign ge1 = t1 >= {1'b0, literal};
  assign r1  = ge1 ? LitW'(t1 - {1'b0, literal}) : t1[LitW-1:0];
  assign t2  = {r1, dq[62]};
  assign ge2 = t2 >= {1'b0, literal};
  assign r2  = ge2 ? LitW'(t2 - {1'b0, literal}) : t2[LitW-1:0];

  // one character through the parser, fold excluded
  always_comb begin
    phase_next           = phase;
    literal_next         = literal;
    running_sum_next     = running_sum;
    running_product_next = running_product;
    pending_minus_next   = pending_minus;
    pending_divide_next  = pending_divide;
    error_code_next      = error_code;
    if (active) begin
      unique case (phase)
        PH_OPERAND: begin
          if (is_space) begin
            phase_next = phase;
          end else if (is_digit) begin
            literal_next = LitW'(digit);
            phase_next   = PH_LIT;
          end else if (cur_c == CH_NUL || is_op) begin
            error_code_next = ST_SYNTAX;
          end else begin
            error_code_next = ST_BAD_CHAR;
          end
        end
        PH_LIT, PH_TRAIL: begin
          if (is_digit) begin
            if (lit_ext > {4'b0000, LitMax}) error_code_next = ST_LIT_OVF;
            else                            literal_next = lit_ext[LitW-1:0];
          end else if (divide_fault) begin
            error_code_next = ST_DIV_ZERO;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_OP: begin
          if (is_space) begin
            phase_next = phase;
          end else if (is_digit) begin
            literal_next = LitW'(digit);
            phase_next   = PH_TRAIL;
          end else if (cur_c == CH_NUL || is_op) begin
            if (divide_fault) begin
              error_code_next = ST_DIV_ZERO;
            end else if (cur_c == CH_NUL) begin
              phase_next = PH_DONE;
            end else if (cur_c == CH_PLUS || cur_c == CH_MINUS) begin
              running_sum_next     = fold_sum;
              pending_minus_next   = (cur_c == CH_MINUS);
              running_product_next = 64'd1;
              pending_divide_next  = 1'b0;
              phase_next           = PH_OPERAND;
            end else begin
              pending_divide_next = (cur_c == CH_SLASH);
              phase_next          = PH_OPERAND;
            end
          end else begin
            error_code_next = ST_BAD_CHAR;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      phase           <= PH_OPERAND;
      literal         <= '0;
      running_sum     <= '0;
      running_product <= 64'd1;
      pending_minus   <= 1'b0;
      pending_divide  <= 1'b0;
      divide_fault    <= 1'b0;
      error_code      <= ST_OK;
      cur_last        <= 1'b0;
      at_end          <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur_last <= item.last;
        at_end   <= 1'b0;
      end
      if (cmd.to_end) begin
        at_end <= 1'b1;
      end
      if (cmd.step) begin
        phase           <= phase_next;
        literal         <= literal_next;
        running_sum     <= running_sum_next;
        running_product <= running_product_next;
        pending_minus   <= pending_minus_next;
        pending_divide  <= pending_divide_next;
        error_code      <= error_code_next;
      end
      if (cmd.fold_zero) begin
        divide_fault    <= 1'b1;
        running_product <= '0;
        phase           <= PH_OP;
      end
      if (cmd.mul_add) begin
        running_product <= acc + {mreg[31:0], 32'd0};
        phase           <= PH_OP;
      end
      if (cmd.div_done) begin
        running_product <= neg ? 64'd0 - dq : dq;
        phase           <= PH_OP;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) cur_c <= item.ch;
    if (cmd.to_end) cur_c <= CH_NUL;
    if (cmd.mul_lo) mreg <= mul_res;
    if (cmd.mul_hi) begin
      acc  <= mreg;
      mreg <= mul_res;
    end
    if (cmd.div_init) begin
      neg <= running_product[63];
      dq  <= running_product[63] ? 64'd0 - running_product : running_product;
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.div_iter) begin
      dq  <= {dq[61:0], ge1, ge2};
      rem <= r2;
      cnt <= cnt + 5'd1;
    end
    if (cmd.finish) begin
      if (error_code != ST_OK) begin
        result.value  <= '0;
        result.status <= error_code;
      end else begin
        result.value  <= fold_sum;
        result.status <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/infix_expression_evaluator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// infix_expression_evaluator
// Integer infix evaluator fed one character per item.
//
// Input channel (item_valid / item_stall / item): one ASCII character and a
// last flag. Output channel (result_valid / result_stall / result): one
// result per expression, sent after the item marked last, carrying the
// 64-bit value (zero on error) and a status code.
// Each item is accepted in the idle step and then evaluated.
// A character that closes a literal after '*' adds three steps through the
// shared 32x32 multiplier (low half, high half, add) and a re-evaluation;
// after '/' it adds the radix-4 divider (init, iterations retiring 2
// quotient bits a cycle over 64 bits, done) and a re-evaluation. The last
// item adds one end-of-text evaluation (it may close a literal as well)
// and a finish step that loads the result register.
// The result sits in an output register; new items are accepted while it
// waits. A further result waits in its finish step while the receiver
// stalls, and item_stall stays high meanwhile.
// Reset (rst, synchronous) clears the parser state and drops any pending
// result.
// ---------------------------------------------------------------------------
module infix_expression_evaluator (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  iee_pkg::in_item_t   item,
  output logic                result_valid,
  input  wire                 result_stall,
  output iee_pkg::out_item_t  result
);
  import iee_pkg::*;

  iee_cmd_t    cmd;
  iee_status_t st;

  // sequencer: handshakes and fold steps
  iee_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // parser state, arithmetic and the result register
  iee_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

`ifndef SYNTHESIS
  // an error result always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.value == 64'd0))
    else $error("error result with nonzero value");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status <= ST_LIT_OVF))
    else $error("status code out of range");

  // a new result appears only after a finish step
  a_rise_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.finish))
    else $error("result raised without finish");

  // the held result is not overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !cmd.finish)
    else $error("result overwritten under stall");
`endif

endmodule
`default_nettype wire
